// ===== sv/pbcm_pkg.sv =====
// ----------------------------------------------------------------------------
// pbcm_pkg
// Shared types and constants of the packet burst Cinst meter: word layouts,
// operation codes, sequencer states and sizes of the divider and histogram.
// ----------------------------------------------------------------------------
package pbcm_pkg;

    localparam int HIST_BINS = 32;
    localparam int BIN_W     = $clog2(HIST_BINS);

    localparam int TIME_W    = 64;
    localparam int PERIOD_W  = 48;
    localparam int FRAC_W    = 16;
    localparam int DVD_W     = TIME_W + FRAC_W;
    localparam int STEP_W    = $clog2(DVD_W + 1);
    localparam int OCC_W     = 16;
    localparam int CNT_W     = 32;
    localparam int BINV_W    = 6;

    localparam logic [PERIOD_W-1:0] DRAIN_RESET = 48'd882638848;
    localparam logic [PERIOD_W-1:0] DRAIN_MIN   = 48'd65536;
    localparam logic [OCC_W-1:0]    OCC_MAX     = 16'hFFFF;
    localparam logic [CNT_W-1:0]    CNT_MAX     = 32'hFFFF_FFFF;

    localparam logic OP_PACKET = 1'b0;
    localparam logic OP_DUMP   = 1'b1;
    localparam logic KIND_PKT  = 1'b0;
    localparam logic KIND_BIN  = 1'b1;

    typedef struct packed {
        logic              op;
        logic [TIME_W-1:0] arrival_ns;
        logic              marker_in;
    } t_in_word;

    typedef struct packed {
        logic              kind;
        logic [OCC_W-1:0]  occupancy;
        logic              marker_out;
        logic [BINV_W-1:0] bin_value;
        logic [CNT_W-1:0]  bin_count;
        logic              last;
    } t_out_word;

    typedef struct packed {
        logic             rd_en;
        logic [BIN_W-1:0] rd_addr;
        logic             wr_en;
        logic [BIN_W-1:0] wr_addr;
        logic [CNT_W-1:0] wr_data;
    } t_hist_req;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_DIV,
        ST_DIFF,
        ST_OCC,
        ST_HRD,
        ST_HWR,
        ST_POUT,
        ST_DRD,
        ST_DOUT
    } t_state;

endpackage

// ===== sv/pbcm_div.sv =====
// ----------------------------------------------------------------------------
// pbcm_div
// Restoring divider, one quotient bit per cycle: an 80-bit dividend over a
// 48-bit divisor, giving the low 64 bits of the quotient.
// ----------------------------------------------------------------------------
module pbcm_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [pbcm_pkg::DVD_W-1:0]    i_dividend,
    input  logic [pbcm_pkg::PERIOD_W-1:0] i_divisor,
    output logic                          o_done,
    output logic [pbcm_pkg::TIME_W-1:0]   o_quotient
);
    import pbcm_pkg::*;

    logic [DVD_W-1:0]    r_dvd;
    logic [PERIOD_W-1:0] r_dvs;
    logic [PERIOD_W-1:0] r_rem;
    logic [TIME_W-1:0]   r_quo;
    logic [STEP_W-1:0]   r_cnt;
    logic                r_busy;
    logic                r_done;

    logic [PERIOD_W:0]   rem_sh;
    logic                ge;
    logic [PERIOD_W:0]   rem_sub;

    always_comb begin
        rem_sh  = {r_rem, r_dvd[DVD_W-1]};
        ge      = (rem_sh >= {1'b0, r_dvs});
        rem_sub = rem_sh - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == STEP_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The remainder stays below the divisor, so it always fits in 48 bits.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
            r_rem <= ge ? rem_sub[PERIOD_W-1:0] : rem_sh[PERIOD_W-1:0];
            r_quo <= {r_quo[TIME_W-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== sv/pbcm_hist.sv =====
// ----------------------------------------------------------------------------
// pbcm_hist
// Occupancy histogram store: one write and one registered read per cycle.
// Per-bin valid bits make never-written bins read as zero after reset.
// ----------------------------------------------------------------------------
module pbcm_hist (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  pbcm_pkg::t_hist_req        i_req,
    output logic [pbcm_pkg::CNT_W-1:0] o_rd_count
);
    import pbcm_pkg::*;

    logic [CNT_W-1:0]     r_mem [HIST_BINS];
    logic [HIST_BINS-1:0] r_valid;
    logic [CNT_W-1:0]     r_rd_data;
    logic                 r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_valid[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_vld <= r_valid[i_req.rd_addr];
            end
        end
    end

    assign o_rd_count = r_rd_vld ? r_rd_data : '0;

endmodule

// ===== sv/packet_burst_cinst_meter.sv =====
// ----------------------------------------------------------------------------
// packet_burst_cinst_meter
// Receiver bucket model of packet bursts: each packet word yields its bucket
// occupancy and bumps a histogram bin; a dump word reads out every bin.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-------------------------
//   in      | input     | i_in_valid/o_in_ready | i_in_data  (t_in_word)
//   out     | output    | o_out_valid/i_out_ready | o_out_data (t_out_word)
//   cfg     | input     | i_cfg_valid/o_cfg_ready | i_cfg_data (drain period)
//
// A packet word is worked off before the next input is taken, waiting on
// the 80-step divider that works out the drained total; the first packet
// skips the divider.
// A dump word makes one histogram read per bin.
// Reset is synchronous and clears the bucket state and all histogram bins
// at once; the block takes input in the first cycle after reset.
// A stalled output holds the sequencer in its emit state; one finished
// word may wait in the output register while the next input is taken.
// ----------------------------------------------------------------------------
module packet_burst_cinst_meter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  pbcm_pkg::t_in_word            i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output pbcm_pkg::t_out_word           o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [pbcm_pkg::PERIOD_W-1:0] i_cfg_data
);
    import pbcm_pkg::*;

    t_state              r_state;
    t_state              n_state;
    logic                r_op;
    logic [TIME_W-1:0]   r_time;
    logic                r_marker;
    logic                r_started;
    logic [TIME_W-1:0]   r_origin;
    logic [OCC_W-1:0]    r_prev_occ;
    logic [TIME_W-1:0]   r_prev_drained;
    logic [TIME_W:0]     r_diff;
    logic [OCC_W-1:0]    r_occ;
    logic [BIN_W-1:0]    r_idx;
    logic [PERIOD_W-1:0] r_period;
    logic                r_out_vld;
    t_out_word           r_out;

    logic                in_acc;
    logic                out_free;
    logic                out_load;
    logic                div_start;
    logic                div_done;
    logic [TIME_W-1:0]   div_quo;
    logic [PERIOD_W-1:0] period_eff;
    logic [TIME_W-1:0]   elapsed;
    t_hist_req           hist_req;
    logic [CNT_W-1:0]    hist_count;
    logic [BIN_W-1:0]    occ_bin;
    logic                idx_last;
    logic [OCC_W-1:0]    occ_nx;
    logic [OCC_W:0]      base;
    logic [TIME_W-1:0]   up;
    logic [OCC_W+1:0]    sum_up;
    t_out_word           n_out;

    assign in_acc   = i_in_valid & o_in_ready;
    assign out_free = ~r_out_vld | i_out_ready;
    assign idx_last = (r_idx == BIN_W'(HIST_BINS - 1));

    // Periods below one nanosecond are taken as exactly one nanosecond.
    assign period_eff = (r_period < DRAIN_MIN) ? DRAIN_MIN : r_period;
    // Arrivals before the origin count as no elapsed time.
    assign elapsed    = (r_time >= r_origin) ? (r_time - r_origin) : '0;
    assign occ_bin    = (r_occ >= OCC_W'(HIST_BINS - 1)) ? BIN_W'(HIST_BINS - 1)
                                                         : r_occ[BIN_W-1:0];

    pbcm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({elapsed, {FRAC_W{1'b0}}}),
        .i_divisor  (period_eff),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    pbcm_hist u_hist (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (hist_req),
        .o_rd_count (hist_count)
    );

    // New occupancy from the registered change in drained total.
    always_comb begin
        base   = {1'b0, r_prev_occ} + 1'b1;
        up     = ~r_diff[TIME_W-1:0] + 1'b1;
        sum_up = {1'b0, base} + {2'b00, up[OCC_W-1:0]};
        occ_nx = '0;
        if (!r_diff[TIME_W]) begin
            if ((r_diff[TIME_W-1:OCC_W+1] == '0) && (r_diff[OCC_W:0] < base)) begin
                occ_nx = (base - r_diff[OCC_W:0] > {1'b0, OCC_MAX})
                         ? OCC_MAX : OCC_W'(base - r_diff[OCC_W:0]);
            end
        end else begin
            // The drained total fell: occupancy grows by one plus the drop.
            if ((up[TIME_W-1:OCC_W] != '0) || (sum_up > {2'b00, OCC_MAX})) begin
                occ_nx = OCC_MAX;
            end else begin
                occ_nx = sum_up[OCC_W-1:0];
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = (i_in_data.op == OP_DUMP) ? ST_DRD : ST_START;
                end
            end
            ST_START: n_state = r_started ? ST_DIV : ST_HRD;
            ST_DIV:   if (div_done) n_state = ST_DIFF;
            ST_DIFF:  n_state = ST_OCC;
            ST_OCC:   n_state = ST_HRD;
            ST_HRD:   n_state = ST_HWR;
            ST_HWR:   n_state = ST_POUT;
            ST_POUT:  if (out_free) n_state = ST_IDLE;
            ST_DRD:   n_state = ST_DOUT;
            ST_DOUT: begin
                if (out_free) begin
                    n_state = idx_last ? ST_IDLE : ST_DRD;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready       = 1'b0;
        div_start        = 1'b0;
        out_load         = 1'b0;
        hist_req.rd_en   = 1'b0;
        hist_req.rd_addr = occ_bin;
        hist_req.wr_en   = 1'b0;
        hist_req.wr_addr = occ_bin;
        hist_req.wr_data = (hist_count == CNT_MAX) ? CNT_MAX : hist_count + 1'b1;
        n_out            = '0;
        unique case (r_state)
            ST_IDLE:  o_in_ready = 1'b1;
            ST_START: div_start = r_started;
            ST_HRD:   hist_req.rd_en = 1'b1;
            ST_HWR:   hist_req.wr_en = 1'b1;
            ST_POUT: begin
                out_load         = out_free;
                n_out.kind       = KIND_PKT;
                n_out.occupancy  = r_occ;
                n_out.marker_out = r_marker;
                n_out.last       = 1'b1;
            end
            ST_DRD: begin
                hist_req.rd_en   = 1'b1;
                hist_req.rd_addr = r_idx;
            end
            ST_DOUT: begin
                out_load        = out_free;
                n_out.kind      = KIND_BIN;
                n_out.bin_value = BINV_W'(r_idx);
                n_out.bin_count = hist_count;
                n_out.last      = idx_last;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_started      <= 1'b0;
            r_origin       <= '0;
            r_prev_occ     <= '0;
            r_prev_drained <= '0;
            r_period       <= DRAIN_RESET;
            r_out_vld      <= 1'b0;
            r_idx          <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_period <= i_cfg_data;
            end
            if ((r_state == ST_START) && !r_started) begin
                r_started      <= 1'b1;
                r_origin       <= r_time;
                r_prev_occ     <= '0;
                r_prev_drained <= '0;
            end
            if (r_state == ST_OCC) begin
                r_prev_occ     <= occ_nx;
                r_prev_drained <= div_quo;
            end
            if (in_acc) begin
                r_idx <= '0;
            end else if ((r_state == ST_DOUT) && out_free && !idx_last) begin
                r_idx <= r_idx + 1'b1;
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op     <= i_in_data.op;
            r_time   <= i_in_data.arrival_ns;
            r_marker <= i_in_data.marker_in;
        end
        if (r_state == ST_START) begin
            r_occ <= '0;
        end else if (r_state == ST_OCC) begin
            r_occ <= occ_nx;
        end
        if (r_state == ST_DIFF) begin
            r_diff <= {1'b0, div_quo} - {1'b0, r_prev_drained};
        end
        if (out_load) begin
            r_out <= n_out;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIV))
        else $error("divider finished outside its wait state");

    a_hist_write_pkt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hist_req.wr_en |-> (r_op == OP_PACKET) && r_started)
        else $error("histogram written outside a packet update");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_in_ready)
        else $error("input taken again before the previous word was worked off");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!o_out_valid || i_out_ready))
        else $error("output register overwritten while its word waits");
`endif

endmodule

// ===== tb/packet_burst_cinst_meter_test.sv =====
// ----------------------------------------------------------------------------
// packet_burst_cinst_meter_test
// Self-checking bench for the packet burst Cinst meter. A bit-true bucket and
// histogram predictor is fed from every accepted input word, and every output
// word is compared field by field with the oldest prediction. Directed checks
// cover the first packet, bucket fill and drain, times before the origin,
// saturation and the drain period extremes; random phases then run bursts,
// steady flow, backward jumps and dumps under random idling and stalls.
// ----------------------------------------------------------------------------
module packet_burst_cinst_meter_test;
    import pbcm_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    t_in_word            in_data   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    t_out_word           out_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [PERIOD_W-1:0] cfg_data  = '0;

    // Predicted state of the block
    logic [PERIOD_W-1:0] period_q16;
    logic                bucket_started;
    logic [TIME_W-1:0]   bucket_origin;
    logic [OCC_W-1:0]    bucket_level;
    logic [TIME_W-1:0]   bucket_drained;
    logic [CNT_W-1:0]    bin_tally [HIST_BINS];
    t_out_word           meter_words_due [$];

    logic [TIME_W-1:0]   arrival_clock = '0;
    bit                  steady_flow = 1'b0;
    int unsigned         hold_off_cycles = 0;
    int unsigned         cycle_count = 0;
    int unsigned         fault_count = 0;
    int unsigned         packets_sent = 0;
    int unsigned         dumps_sent = 0;
    int unsigned         period_writes = 0;
    int unsigned         results_checked = 0;
    logic [OCC_W-1:0]    peak_occupancy = '0;

    packet_burst_cinst_meter u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d words outstanding",
                     cycle_count, meter_words_due.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic int unsigned idle_gap();
        return steady_flow ? 0 : $urandom_range(0, 14);
    endfunction

    task automatic report_fault(input string msg);
        $display("[%0d] MISMATCH: %s", cycle_count, msg);
        fault_count++;
    endtask

    // Advances the bucket by one packet arriving at time t and returns the
    // new occupancy.
    function automatic logic [OCC_W-1:0] bucket_step(input logic [TIME_W-1:0] t);
        logic [PERIOD_W-1:0] divisor;
        logic [DVD_W-1:0]    quotient;
        logic [TIME_W-1:0]   elapsed;
        logic [TIME_W-1:0]   drained;
        logic [TIME_W-1:0]   fall;
        logic [TIME_W-1:0]   rise;
        logic [16:0]         base;
        logic [16:0]         diff;
        logic [OCC_W-1:0]    level;
        if (!bucket_started) begin
            bucket_started = 1'b1;
            bucket_origin  = t;
            bucket_drained = '0;
            level          = '0;
        end else begin
            divisor  = (period_q16 < DRAIN_MIN) ? DRAIN_MIN : period_q16;
            elapsed  = (t >= bucket_origin) ? t - bucket_origin : '0;
            quotient = {elapsed, {FRAC_W{1'b0}}} / {{(DVD_W-PERIOD_W){1'b0}}, divisor};
            drained  = quotient[TIME_W-1:0];
            base     = {1'b0, bucket_level} + 17'd1;
            if (drained >= bucket_drained) begin
                fall = drained - bucket_drained;
                if (fall >= 64'(base)) begin
                    level = '0;
                end else begin
                    diff  = base - fall[16:0];
                    level = diff[16] ? OCC_MAX : diff[15:0];
                end
            end else begin
                // The drained total went backwards, so the bucket grows.
                rise = bucket_drained - drained;
                if (rise >= 64'(OCC_MAX) || 64'(base) + rise > 64'(OCC_MAX)) begin
                    level = OCC_MAX;
                end else begin
                    level = base[15:0] + rise[15:0];
                end
            end
            bucket_drained = drained;
        end
        bucket_level = level;
        return level;
    endfunction

    function automatic void meter_update(input t_in_word w);
        t_out_word        r;
        logic [OCC_W-1:0] occ;
        int               bin;
        int               i;
        if (w.op == OP_PACKET) begin
            occ = bucket_step(w.arrival_ns);
            bin = (occ >= OCC_W'(HIST_BINS - 1)) ? HIST_BINS - 1 : int'(occ);
            if (bin_tally[bin] != CNT_MAX) bin_tally[bin]++;
            r            = '0;
            r.kind       = KIND_PKT;
            r.occupancy  = occ;
            r.marker_out = w.marker_in;
            r.last       = 1'b1;
            meter_words_due = {meter_words_due, r};
            packets_sent++;
            if (occ > peak_occupancy) peak_occupancy = occ;
        end else begin
            for (i = 0; i < HIST_BINS; i++) begin
                r           = '0;
                r.kind      = KIND_BIN;
                r.bin_value = BINV_W'(i);
                r.bin_count = bin_tally[i];
                r.last      = (i == HIST_BINS - 1);
                meter_words_due = {meter_words_due, r};
            end
            dumps_sent++;
        end
    endfunction

    task automatic check_word(input t_out_word got);
        t_out_word want;
        if (meter_words_due.size() == 0) begin
            report_fault($sformatf("unexpected result word %h", got));
        end else begin
            want = meter_words_due.pop_front();
            results_checked++;
            if (got.kind !== want.kind)
                report_fault($sformatf("word %0d kind %0d, expected %0d",
                                       results_checked, got.kind, want.kind));
            if (got.occupancy !== want.occupancy)
                report_fault($sformatf("word %0d occupancy %0d, expected %0d",
                                       results_checked, got.occupancy, want.occupancy));
            if (got.marker_out !== want.marker_out)
                report_fault($sformatf("word %0d marker %0d, expected %0d",
                                       results_checked, got.marker_out, want.marker_out));
            if (got.bin_value !== want.bin_value)
                report_fault($sformatf("word %0d bin %0d, expected %0d",
                                       results_checked, got.bin_value, want.bin_value));
            if (got.bin_count !== want.bin_count)
                report_fault($sformatf("word %0d bin count %0d, expected %0d",
                                       results_checked, got.bin_count, want.bin_count));
            if (got.last !== want.last)
                report_fault($sformatf("word %0d last %0d, expected %0d",
                                       results_checked, got.last, want.last));
        end
    endtask

    // Output side: random stalls before each word, plus a long hold when the
    // stall test asks for one.
    initial begin : result_sink
        int unsigned gap;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            if (hold_off_cycles > 0) begin
                out_ready <= 1'b0;
                repeat (hold_off_cycles) @(negedge clk);
                hold_off_cycles = 0;
            end
            gap = idle_gap();
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            check_word(out_data);
            @(negedge clk);
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance
    // with valid still high, so a back-to-back word keeps it high.
    task automatic send_word(input logic op, input logic [TIME_W-1:0] t, input logic marker);
        t_in_word    w;
        int unsigned gap;
        w.op         = op;
        w.arrival_ns = t;
        w.marker_in  = marker;
        gap = idle_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        meter_update(w);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(negedge clk); while (meter_words_due.size() != 0);
    endtask

    task automatic write_drain_period(input logic [PERIOD_W-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        period_q16 = value;
        period_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_first_packet();
        // A dump before any packet shows an empty histogram.
        send_word(OP_DUMP, '0, 1'b0);
        send_word(OP_PACKET, 64'd1000, 1'b1);
    endtask

    task automatic test_bucket_fill();
        send_word(OP_PACKET, 64'd1000, 1'b0);
        send_word(OP_PACKET, 64'd1000, 1'b1);
        send_word(OP_PACKET, 64'd1000, 1'b0);
        // Ten drain periods later the bucket has emptied.
        send_word(OP_PACKET, 64'd1000 + 64'd13468 * 10, 1'b1);
    endtask

    task automatic test_time_extremes();
        send_word(OP_PACKET, '0, 1'b0);
        send_word(OP_PACKET, '1, 1'b1);
        // Back before the origin after a huge drain, so the bucket saturates.
        send_word(OP_PACKET, '0, 1'b0);
        send_word(OP_PACKET, '0, 1'b1);
    endtask

    task automatic test_period_extremes();
        write_drain_period(PERIOD_W'(100));
        send_word(OP_PACKET, 64'd1010, 1'b0);
        write_drain_period('1);
        send_word(OP_PACKET, 64'h0000_1000_0000_0000, 1'b1);
        write_drain_period(DRAIN_MIN);
        send_word(OP_PACKET, 64'd1500, 1'b0);
        write_drain_period(DRAIN_RESET);
        send_word(OP_DUMP, '1, 1'b1);
    endtask

    task automatic test_random_traffic(input logic [PERIOD_W-1:0] period, input int items);
        logic [TIME_W-1:0] scale;
        int unsigned       pick;
        int unsigned       run_left;
        int                n;
        run_left = 0;
        write_drain_period(period);
        scale = TIME_W'(((period < DRAIN_MIN) ? DRAIN_MIN : period) >> FRAC_W);
        for (n = 0; n < items; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                send_word(OP_DUMP, {$urandom, $urandom}, 1'($urandom_range(0, 1)));
            end else begin
                // Bursts of closely spaced packets push the bucket up into
                // the high bins; the rest let it drain or jump about.
                if (run_left == 0 && pick < 8) run_left = $urandom_range(15, 40);
                if (run_left > 0) begin
                    run_left--;
                    arrival_clock += scale * $urandom_range(0, 30) / 100;
                end else if (pick < 50) begin
                    arrival_clock += scale * $urandom_range(0, 70) / 100;
                end else if (pick < 85) begin
                    arrival_clock += scale * $urandom_range(80, 300) / 100;
                end else if (pick < 92) begin
                    arrival_clock += scale * $urandom_range(3, 60);
                end else if (pick < 97) begin
                    if (arrival_clock < scale * 20) arrival_clock = '0;
                    else arrival_clock -= scale * $urandom_range(1, 20);
                end else begin
                    arrival_clock = {$urandom, $urandom};
                end
                send_word(OP_PACKET, arrival_clock, 1'($urandom_range(0, 1)));
            end
            if ($urandom_range(0, 39) == 0) wait_drained();
        end
    endtask

    task automatic test_output_stall();
        int n;
        wait_drained();
        steady_flow     = 1'b1;
        hold_off_cycles = 2500;
        for (n = 0; n < 12; n++) begin
            arrival_clock += $urandom_range(0, 4000);
            send_word(OP_PACKET, arrival_clock, 1'($urandom_range(0, 1)));
        end
        send_word(OP_DUMP, '0, 1'b0);
        steady_flow = 1'b0;
        wait_drained();
    endtask

    initial begin : run_tests
        int i;
        period_q16     = DRAIN_RESET;
        bucket_started = 1'b0;
        bucket_origin  = '0;
        bucket_level   = '0;
        bucket_drained = '0;
        for (i = 0; i < HIST_BINS; i++) bin_tally[i] = '0;

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        test_first_packet();
        test_bucket_fill();
        test_time_extremes();
        test_period_extremes();

        arrival_clock = 64'd5_000_000;
        test_random_traffic(DRAIN_RESET, 60);
        steady_flow = 1'b1;
        test_random_traffic(DRAIN_MIN, 60);
        steady_flow = 1'b0;
        test_random_traffic('1, 50);
        test_random_traffic(PERIOD_W'($urandom_range(65536, 32'h8000_0000)), 70);
        test_random_traffic({16'($urandom_range(0, 65535)), 32'($urandom)}, 60);
        test_random_traffic(PERIOD_W'($urandom_range(0, 65535)), 42);
        test_output_stall();
        send_word(OP_DUMP, '0, 1'b1);

        wait_drained();
        repeat (2 * HIST_BINS + 100) @(negedge clk);

        $display("Ran %0d packet words and %0d dump words across %0d drain period settings,",
                 packets_sent, dumps_sent, period_writes);
        $display("checked %0d result words; highest occupancy seen %0d.",
                 results_checked, peak_occupancy);
        if (fault_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
